[rtl/c6502_pkg.sv]
// Shared types, codes and constants of the 6502 subset executor.
`default_nettype none
package c6502_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int QDEPTH        = 2;

  // Item kinds; every operation code outside the list is classified as K_NONE.
  localparam logic [2:0] K_WRITE  = 3'd0;
  localparam logic [2:0] K_RESET  = 3'd1;
  localparam logic [2:0] K_EXEC   = 3'd2;
  localparam logic [2:0] K_VBLANK = 3'd3;
  localparam logic [2:0] K_READ   = 3'd4;
  localparam logic [2:0] K_NONE   = 3'd5;

  localparam logic [1:0] HALT_RUN  = 2'd0;
  localparam logic [1:0] HALT_BRK  = 2'd1;
  localparam logic [1:0] HALT_UNK  = 2'd2;

  localparam logic [15:0] PPU_STATUS_ADDR = 16'h2002;
  localparam logic [15:0] VEC_LO_ADDR     = 16'hFFFC;
  localparam logic [15:0] VEC_HI_ADDR     = 16'hFFFD;
  localparam logic [7:0]  VBLANK_BIT      = 8'h80;
  localparam logic [7:0]  SP_RESET        = 8'hFD;
  localparam logic [7:0]  FLAGS_RESET     = 8'h24;
  localparam logic [7:0]  FLAG_I          = 8'h04;
  localparam logic [7:0]  FLAG_N          = 8'h80;
  localparam logic [7:0]  FLAG_Z          = 8'h02;

  localparam logic [7:0] OP_NOP = 8'hEA, OP_BRK = 8'h00, OP_LDAI = 8'hA9, OP_LDAZ = 8'hA5;
  localparam logic [7:0] OP_LDAZX = 8'hB5, OP_LDAA = 8'hAD, OP_LDAAX = 8'hBD;
  localparam logic [7:0] OP_LDAAY = 8'hB9, OP_LDXI = 8'hA2, OP_SEI = 8'h78, OP_TXS = 8'h9A;
  localparam logic [7:0] OP_TAX = 8'hAA, OP_TXA = 8'h8A, OP_DEX = 8'hCA, OP_INX = 8'hE8;
  localparam logic [7:0] OP_TAY = 8'hA8, OP_TYA = 8'h98, OP_DEY = 8'h88, OP_INY = 8'hC8;
  localparam logic [7:0] OP_STXZ = 8'h86, OP_STXZY = 8'h96, OP_STXA = 8'h8E, OP_BPL = 8'h10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } qhead_t;

endpackage
`default_nettype wire

[rtl/c6502_front.sv]
// Front end: accepts input words, classifies them and queues them for execution.
`default_nettype none
module c6502_front #(
  parameter int ADDR_BITS = c6502_pkg::ADDR_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [2:0]          in_tuser,
  input  wire logic [ADDR_BITS-1:0] in_addr,
  input  wire logic [7:0]          in_data,
  input  wire logic                busy,
  input  wire logic                pop,
  output c6502_pkg::qhead_t        head
);
  localparam int PW = (c6502_pkg::QDEPTH > 1) ? $clog2(c6502_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(c6502_pkg::QDEPTH + 1);

  c6502_pkg::item_t q_r [c6502_pkg::QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic push;
  c6502_pkg::item_t cls;

  always_comb begin
    cls.addr = 16'(in_addr);
    cls.data = in_data;
    if (in_tuser <= c6502_pkg::K_READ) begin
      cls.kind = in_tuser;
    end else begin
      cls.kind = c6502_pkg::K_NONE;
    end
  end

  assign in_tready = (cnt_r != CW'(c6502_pkg::QDEPTH)) && !busy;
  assign push      = in_tvalid && in_tready;
  assign head.vld  = (cnt_r != '0);
  assign head.item = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == PW'(c6502_pkg::QDEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(c6502_pkg::QDEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule
`default_nettype wire

[rtl/c6502_exec.sv]
// Back end: instruction sequencer, 2**ADDR_BITS-byte memory (64 KB by default) and the result register.
`default_nettype none
module c6502_exec #(
  parameter int ADDR_BITS = c6502_pkg::ADDR_BITS_DEF,
  parameter int OUT_W     = 72
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire c6502_pkg::qhead_t head,
  output logic                   pop,
  output logic                   busy,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata
);
  localparam int AW    = ADDR_BITS;
  localparam int DEPTH = 1 << AW;
  localparam int PAYW  = AW + 50;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDW  = 4'd1;
  localparam logic [3:0] S_VL   = 4'd2;
  localparam logic [3:0] S_VH   = 4'd3;
  localparam logic [3:0] S_OPC  = 4'd4;
  localparam logic [3:0] S_OP1  = 4'd5;
  localparam logic [3:0] S_OP2  = 4'd6;
  localparam logic [3:0] S_DAT  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] f;
    f = p & ~(c6502_pkg::FLAG_N | c6502_pkg::FLAG_Z);
    if (v == 8'h00) f = f | c6502_pkg::FLAG_Z;
    if (v[7]) f = f | c6502_pkg::FLAG_N;
    return f;
  endfunction

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic [AW:0] clr_r;

  logic [3:0]  st_r, st_nxt;
  logic [AW-1:0] pc_r, pc_nxt;
  logic [7:0]  a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt, p_r, p_nxt;
  logic [7:0]  ppu_r, ppu_nxt, snap_r, snap_nxt, rdv_r, rdv_nxt;
  logic [7:0]  opc_r, opc_nxt, lo_r, lo_nxt;
  logic [1:0]  halt_r, halt_nxt;
  logic        rdppu_r, rdppu_nxt;

  logic [AW-1:0] raddr, waddr;
  logic [7:0]    wdata;
  logic          we, cpu_rd;
  logic [7:0]    val;
  logic          out_load;
  logic [PAYW-1:0] pay;

  assign busy = !clr_r[AW];
  assign val  = rdppu_r ? snap_r : mem_q;
  assign out_load = (st_r == S_OUT) && (!out_tvalid || out_tready);

  always_comb begin
    st_nxt = st_r;   pc_nxt = pc_r;   a_nxt = a_r;   x_nxt = x_r;   y_nxt = y_r;
    sp_nxt = sp_r;   p_nxt = p_r;     ppu_nxt = ppu_r; snap_nxt = snap_r;
    rdv_nxt = rdv_r; opc_nxt = opc_r; lo_nxt = lo_r; halt_nxt = halt_r;
    rdppu_nxt = 1'b0;
    raddr = pc_r;    cpu_rd = 1'b0;   we = 1'b0;     waddr = '0; wdata = x_r;
    pop = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (head.vld && !busy) begin
          pop     = 1'b1;
          rdv_nxt = 8'h00;
          st_nxt  = S_OUT;
          case (head.item.kind)
            c6502_pkg::K_WRITE: begin
              we    = 1'b1;
              waddr = AW'(head.item.addr);
              wdata = head.item.data;
            end
            c6502_pkg::K_READ: begin
              raddr  = AW'(head.item.addr);
              st_nxt = S_RDW;
            end
            c6502_pkg::K_VBLANK: ppu_nxt = ppu_r | c6502_pkg::VBLANK_BIT;
            c6502_pkg::K_RESET: begin
              raddr  = AW'(c6502_pkg::VEC_LO_ADDR);
              st_nxt = S_VL;
            end
            c6502_pkg::K_EXEC: begin
              if (halt_r == c6502_pkg::HALT_RUN) begin
                cpu_rd = 1'b1;
                pc_nxt = pc_r + AW'(1);
                st_nxt = S_OPC;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDW: begin
        rdv_nxt = mem_q;
        st_nxt  = S_OUT;
      end
      S_VL: begin
        lo_nxt = mem_q;
        raddr  = AW'(c6502_pkg::VEC_HI_ADDR);
        st_nxt = S_VH;
      end
      S_VH: begin
        pc_nxt = AW'({mem_q, lo_r});
        sp_nxt = c6502_pkg::SP_RESET;
        p_nxt  = c6502_pkg::FLAGS_RESET;
        a_nxt = 8'h00; x_nxt = 8'h00; y_nxt = 8'h00;
        halt_nxt = c6502_pkg::HALT_RUN;
        st_nxt = S_OUT;
      end
      S_OPC: begin
        opc_nxt = val;
        st_nxt  = S_OUT;
        unique case (val)
          c6502_pkg::OP_NOP: ;
          c6502_pkg::OP_BRK: halt_nxt = c6502_pkg::HALT_BRK;
          c6502_pkg::OP_SEI: p_nxt = p_r | c6502_pkg::FLAG_I;
          c6502_pkg::OP_TXS: sp_nxt = x_r;
          c6502_pkg::OP_TAX: begin x_nxt = a_r; p_nxt = nz(p_r, a_r); end
          c6502_pkg::OP_TXA: begin a_nxt = x_r; p_nxt = nz(p_r, x_r); end
          c6502_pkg::OP_TAY: begin y_nxt = a_r; p_nxt = nz(p_r, a_r); end
          c6502_pkg::OP_TYA: begin a_nxt = y_r; p_nxt = nz(p_r, y_r); end
          c6502_pkg::OP_DEX: begin x_nxt = x_r - 8'd1; p_nxt = nz(p_r, x_r - 8'd1); end
          c6502_pkg::OP_INX: begin x_nxt = x_r + 8'd1; p_nxt = nz(p_r, x_r + 8'd1); end
          c6502_pkg::OP_DEY: begin y_nxt = y_r - 8'd1; p_nxt = nz(p_r, y_r - 8'd1); end
          c6502_pkg::OP_INY: begin y_nxt = y_r + 8'd1; p_nxt = nz(p_r, y_r + 8'd1); end
          c6502_pkg::OP_LDAI, c6502_pkg::OP_LDAZ, c6502_pkg::OP_LDAZX, c6502_pkg::OP_LDAA,
          c6502_pkg::OP_LDAAX, c6502_pkg::OP_LDAAY, c6502_pkg::OP_LDXI, c6502_pkg::OP_STXZ,
          c6502_pkg::OP_BPL: begin
            cpu_rd = 1'b1;
            pc_nxt = pc_r + AW'(1);
            st_nxt = S_OP1;
          end
          c6502_pkg::OP_STXZY, c6502_pkg::OP_STXA: begin
            // These operand fetches read memory directly, without the status side effect.
            pc_nxt = pc_r + AW'(1);
            st_nxt = S_OP1;
          end
          default: halt_nxt = c6502_pkg::HALT_UNK;
        endcase
      end
      S_OP1: begin
        lo_nxt = val;
        st_nxt = S_OUT;
        case (opc_r)
          c6502_pkg::OP_LDAI: begin a_nxt = val; p_nxt = nz(p_r, val); end
          c6502_pkg::OP_LDXI: begin x_nxt = val; p_nxt = nz(p_r, val); end
          c6502_pkg::OP_BPL: begin
            if (!p_r[7]) pc_nxt = pc_r + AW'({{8{val[7]}}, val});
          end
          c6502_pkg::OP_STXZ: begin we = 1'b1; waddr = AW'(val); end
          c6502_pkg::OP_STXZY: begin we = 1'b1; waddr = AW'(8'(val + y_r)); end
          c6502_pkg::OP_LDAZ: begin
            raddr = AW'(val); cpu_rd = 1'b1; st_nxt = S_DAT;
          end
          c6502_pkg::OP_LDAZX: begin
            raddr = AW'(8'(val + x_r)); cpu_rd = 1'b1; st_nxt = S_DAT;
          end
          c6502_pkg::OP_STXA: begin pc_nxt = pc_r + AW'(1); st_nxt = S_OP2; end
          default: begin
            cpu_rd = 1'b1;
            pc_nxt = pc_r + AW'(1);
            st_nxt = S_OP2;
          end
        endcase
      end
      S_OP2: begin
        st_nxt = S_DAT;
        cpu_rd = 1'b1;
        case (opc_r)
          c6502_pkg::OP_STXA: begin
            cpu_rd = 1'b0;
            we     = 1'b1;
            waddr  = AW'({val, lo_r});
            st_nxt = S_OUT;
          end
          c6502_pkg::OP_LDAAX: raddr = AW'({val, lo_r}) + AW'(x_r);
          c6502_pkg::OP_LDAAY: raddr = AW'({val, lo_r}) + AW'(y_r);
          default:  raddr = AW'({val, lo_r});
        endcase
      end
      S_DAT: begin
        a_nxt  = val;
        p_nxt  = nz(p_r, val);
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (cpu_rd && raddr == AW'(c6502_pkg::PPU_STATUS_ADDR)) begin
      rdppu_nxt = 1'b1;
      snap_nxt  = ppu_r;
      ppu_nxt   = ppu_r & ~c6502_pkg::VBLANK_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pc_r <= '0; a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00;
      sp_r <= c6502_pkg::SP_RESET; p_r <= c6502_pkg::FLAGS_RESET; ppu_r <= 8'h00;
      halt_r <= c6502_pkg::HALT_RUN; rdppu_r <= 1'b0; clr_r <= '0; out_tvalid <= 1'b0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt;
      sp_r <= sp_nxt; p_r <= p_nxt; ppu_r <= ppu_nxt; halt_r <= halt_nxt;
      rdppu_r <= rdppu_nxt;
      if (busy) clr_r <= clr_r + (AW+1)'(1);
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt; rdv_r <= rdv_nxt; opc_r <= opc_nxt; lo_r <= lo_nxt;
    if (out_load) out_tdata <= OUT_W'(pay);
  end

  assign pay = {halt_r, rdv_r, p_r, sp_r, y_r, x_r, a_r, pc_r};

  // One-read, one-write memory; the clearing pass owns the write port after reset.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_r[AW-1:0]] <= 8'h00;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/cpu_6502_subset_executor_core.sv]
// Top level of the 6502 subset executor: front queue and execution back end.
//
//  channel | dir | handshake          | contents
//  in_     | in  | in_tvalid/tready   | tuser: operation; tdata: address, data
//  out_    | out | out_tvalid/tready  | tdata: pc, a, x, y, sp, flags, read_data, halt
//
// An item's time in the back end is set by the single memory read port: an
// instruction makes up to four dependent reads (opcode, two operand bytes, data).
// After reset a clearing pass zeroes the memory; no word is taken then.
// The front queue keeps taking words while the back end works or the output stalls, until it is full.
`default_nettype none
module cpu_6502_subset_executor_core #(
  parameter int ADDR_BITS = c6502_pkg::ADDR_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire logic [2:0] in_tuser,                              // operation
  input  wire logic [((ADDR_BITS+15)/8)*8-1:0] in_tdata,         // address, data
  output logic      out_tvalid,
  input  wire logic out_tready,
  // out_pc, out_a, out_x, out_y, out_sp, out_flags, read_data, halt_state
  output logic [((ADDR_BITS+57)/8)*8-1:0] out_tdata
);
  localparam int OUT_W = ((ADDR_BITS + 57) / 8) * 8;

  c6502_pkg::qhead_t head;
  logic pop, busy;

  c6502_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_addr(in_tdata[ADDR_BITS-1:0]),
    .in_data(in_tdata[ADDR_BITS+7:ADDR_BITS]), .busy(busy), .pop(pop), .head(head)
  );

  c6502_exec #(.ADDR_BITS(ADDR_BITS), .OUT_W(OUT_W)) u_exec (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop), .busy(busy),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

[rtl/c6502_checker.sv]
// Port-level checker for the 6502 subset executor, bound to the top level.
`default_nettype none
module c6502_checker #(
  parameter int ADDR_BITS = c6502_pkg::ADDR_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [((ADDR_BITS+57)/8)*8-1:0] out_tdata
);
  localparam int HB = ADDR_BITS + 48;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word shown straight after reset");

  a_clear_pass: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input taken during memory clearing pass");

  a_halt_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[HB+1:HB] != 2'd3)
    else $error("invalid halt code reported");

endmodule

bind cpu_6502_subset_executor_core c6502_checker #(.ADDR_BITS(ADDR_BITS)) u_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
